@@ rtl/core/unsorted_key_set_table_defines.svh @@
// Assertion macros shared by the key set table RTL.
`ifndef UNSORTED_KEY_SET_TABLE_DEFINES_SVH
`define UNSORTED_KEY_SET_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UKS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UKS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/uksst_pkg.sv @@
// Package with shared types and constants of the key set table.
`timescale 1ns / 1ps

package uksst_pkg;

	localparam int unsigned OPCODE_W = 2;
	localparam int unsigned KEY_PORT_W = 64;
	localparam int unsigned CAP_W = 6;
	localparam int unsigned POS_W = 5;

	localparam logic [OPCODE_W-1:0] OP_ADD = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_FIND = 2'd2;

	localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} uksst_mem_cmd_t;

endpackage

@@ rtl/core/unsorted_key_set_table.sv @@
// Top level of the unordered key set table with linear search.
// A request is taken only in S_IDLE; S_SEARCH then compares one stored entry per cycle, in
// order, through the single read port of the key memory, and S_DONE registers the result once
// the response slot is free. A new request is stalled until the last one has been answered.
// Reset clears the entry count, the sequencer and the result register; the capacity register
// resets to 32. The key memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`include "unsorted_key_set_table_defines.svh"

module unsorted_key_set_table #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned KEY_BITS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [uksst_pkg::CAP_W-1:0]        capacity_limit,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [uksst_pkg::OPCODE_W-1:0]     opcode,
	input  logic [uksst_pkg::KEY_PORT_W-1:0]   key,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic                               hit,
	output logic [uksst_pkg::POS_W-1:0]        position,
	output logic [uksst_pkg::CAP_W-1:0]        element_count,
	output logic                               rejected_full
);

	localparam int unsigned IDX_W = $clog2(DEPTH);

	logic [uksst_pkg::CAP_W-1:0]  cap_q;
	uksst_pkg::uksst_mem_cmd_t    mem_cmd;
	logic [IDX_W-1:0]             rd_addr;
	logic [IDX_W-1:0]             wr_addr;
	logic [KEY_BITS-1:0]          wr_data;
	logic [KEY_BITS-1:0]          rd_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= uksst_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= capacity_limit;
		end
	end

	uksst_ctrl #(
		.DEPTH(DEPTH),
		.KEY_BITS(KEY_BITS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cap(cap_q),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.opcode(opcode),
		.key(key),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.hit(hit),
		.position(position),
		.element_count(element_count),
		.rejected_full(rejected_full),
		.mem_cmd(mem_cmd),
		.rd_addr(rd_addr),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_data(rd_data)
	);

	uksst_ram #(
		.DEPTH(DEPTH),
		.KEY_BITS(KEY_BITS)
	) u_ram (
		.clk(clk),
		.cmd(mem_cmd),
		.rd_addr(rd_addr),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_data(rd_data)
	);

	`UKS_ASSERT_NOW(a_rej_no_hit, rsp_valid && rejected_full, !hit, "Rejected add reports a hit.")
	`UKS_ASSERT_NOW(a_miss_pos_zero, rsp_valid && !hit, position == '0, "Miss with nonzero position.")
	`UKS_ASSERT_NEXT(a_busy_after_beat, req_valid && !req_stall, req_stall, "Request beat not followed by stall.")
	`UKS_ASSERT_NOW(a_no_rw_overlap, mem_cmd.wr_en, !mem_cmd.rd_en, "Key memory read and written together.")

endmodule

@@ rtl/core/uksst_ram.sv @@
// Key storage memory with one registered read port and one write port.
`timescale 1ns / 1ps

module uksst_ram #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned KEY_BITS = 64
) (
	input  logic                       clk,
	input  uksst_pkg::uksst_mem_cmd_t  cmd,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  logic [KEY_BITS-1:0]        wr_data,
	output logic [KEY_BITS-1:0]        rd_data
);

	logic [KEY_BITS-1:0] mem_q [DEPTH];
	logic [KEY_BITS-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/core/uksst_ctrl.sv @@
// Search sequencer and result register of the key set table.
`timescale 1ns / 1ps

module uksst_ctrl #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned KEY_BITS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [uksst_pkg::CAP_W-1:0]         cap,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [uksst_pkg::OPCODE_W-1:0]      opcode,
	input  logic [uksst_pkg::KEY_PORT_W-1:0]    key,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic                                hit,
	output logic [uksst_pkg::POS_W-1:0]         position,
	output logic [uksst_pkg::CAP_W-1:0]         element_count,
	output logic                                rejected_full,
	output uksst_pkg::uksst_mem_cmd_t           mem_cmd,
	output logic [$clog2(DEPTH)-1:0]            rd_addr,
	output logic [$clog2(DEPTH)-1:0]            wr_addr,
	output logic [KEY_BITS-1:0]                 wr_data,
	input  logic [KEY_BITS-1:0]                 rd_data
);

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned WW = (CNT_W > uksst_pkg::CAP_W) ? CNT_W : uksst_pkg::CAP_W;
	localparam int unsigned PW = (IDX_W > uksst_pkg::POS_W) ? IDX_W : uksst_pkg::POS_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_DONE
	} state_t;

	state_t                          state_q;
	logic [uksst_pkg::OPCODE_W-1:0]  op_q;
	logic [KEY_BITS-1:0]             key_q;
	logic [IDX_W-1:0]                cmp_idx_q;
	logic                            hit_q;
	logic [IDX_W-1:0]                pos_q;
	logic [CNT_W-1:0]                count_q;
	logic                            rsp_valid_q;
	logic                            rsp_hit_q;
	logic [uksst_pkg::POS_W-1:0]     rsp_pos_q;
	logic [uksst_pkg::CAP_W-1:0]     rsp_count_q;
	logic                            rsp_rej_q;

	logic              req_fire;
	logic              slot_free;
	logic              match;
	logic              is_add;
	logic              is_rem;
	logic [IDX_W-1:0]  last_idx;
	logic [WW-1:0]     cap_ext;
	logic [WW-1:0]     depth_ext;
	logic [WW-1:0]     cap_eff;
	logic              room;
	logic              do_append;
	logic              do_move;
	logic [CNT_W-1:0]  count_next;
	logic [WW-1:0]     count_wide;
	logic [PW-1:0]     pos_wide;

	assign req_stall = (state_q != S_IDLE);
	assign req_fire = req_valid && !req_stall;
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign match = (rd_data == key_q);
	assign is_add = (op_q == uksst_pkg::OP_ADD);
	assign is_rem = (op_q == uksst_pkg::OP_REMOVE);
	assign last_idx = IDX_W'(count_q - CNT_W'(1));
	assign cap_ext = WW'(cap);
	assign depth_ext = WW'(DEPTH);
	assign cap_eff = (cap_ext > depth_ext) ? depth_ext : cap_ext;
	assign room = (WW'(count_q) < cap_eff);
	assign do_append = is_add && !hit_q && room;
	assign do_move = is_rem && hit_q;

	always_comb begin
		count_next = count_q;
		if (do_append) begin
			count_next = count_q + CNT_W'(1);
		end else if (do_move) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	assign count_wide = WW'(count_next);
	assign pos_wide = PW'(pos_q);

	always_comb begin
		mem_cmd.wr_en = (state_q == S_DONE) && slot_free && (do_append || do_move);
		wr_addr = do_move ? pos_q : count_q[IDX_W-1:0];
		wr_data = do_move ? rd_data : key_q;
		mem_cmd.rd_en = 1'b0;
		rd_addr = '0;
		case (state_q)
			S_IDLE: begin
				mem_cmd.rd_en = req_fire && (count_q != '0);
			end
			S_SEARCH: begin
				if (match) begin
					mem_cmd.rd_en = (op_q == uksst_pkg::OP_REMOVE);
					rd_addr = last_idx;
				end else if (cmp_idx_q != last_idx) begin
					mem_cmd.rd_en = 1'b1;
					rd_addr = cmp_idx_q + IDX_W'(1);
				end
			end
			default: begin
				mem_cmd.rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= uksst_pkg::OP_FIND;
			key_q <= '0;
			cmp_idx_q <= '0;
			hit_q <= 1'b0;
			pos_q <= '0;
			count_q <= '0;
			rsp_valid_q <= 1'b0;
			rsp_hit_q <= 1'b0;
			rsp_pos_q <= '0;
			rsp_count_q <= '0;
			rsp_rej_q <= 1'b0;
		end else begin
			if (!rsp_stall && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						op_q <= opcode;
						key_q <= key[KEY_BITS-1:0];
						cmp_idx_q <= '0;
						hit_q <= 1'b0;
						pos_q <= '0;
						state_q <= (count_q == '0) ? S_DONE : S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (match) begin
						hit_q <= 1'b1;
						pos_q <= cmp_idx_q;
						state_q <= S_DONE;
					end else if (cmp_idx_q == last_idx) begin
						state_q <= S_DONE;
					end else begin
						cmp_idx_q <= cmp_idx_q + IDX_W'(1);
					end
				end
				S_DONE: begin
					if (slot_free) begin
						count_q <= count_next;
						rsp_valid_q <= 1'b1;
						rsp_hit_q <= hit_q;
						rsp_pos_q <= pos_wide[uksst_pkg::POS_W-1:0];
						rsp_count_q <= count_wide[uksst_pkg::CAP_W-1:0];
						rsp_rej_q <= is_add && !hit_q && !room;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign hit = rsp_hit_q;
	assign position = rsp_pos_q;
	assign element_count = rsp_count_q;
	assign rejected_full = rsp_rej_q;

endmodule
